### hw/rtl/mp80ks_pkg.sv
`timescale 1ns / 1ps

package mp80ks_pkg;

    localparam int KEY_W   = 80;
    localparam int RK_W    = 64;
    localparam int HALF_W  = 32;
    localparam int RND_W   = 5;
    localparam int RNG_W   = 64;
    localparam int ROT_R   = KEY_W - 61;   // rotate left 61 == rotate right 19
    localparam int CNT_LSB = 15;

    localparam logic [RNG_W-1:0] RNG_SEED_RESET = 64'h0123_4567_89AB_CDEF;

    typedef logic [3:0] nibble_t;
    typedef nibble_t sbox_t [16];

    localparam sbox_t SBOX = '{
        4'hC, 4'h5, 4'h6, 4'hB,
        4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8,
        4'h4, 4'h7, 4'h1, 4'h2
    };

    // one round key beat, split into two shares per half
    typedef struct packed {
        logic [RND_W-1:0]  round_index;
        logic [HALF_W-1:0] share0_high;
        logic [HALF_W-1:0] share1_high;
        logic [HALF_W-1:0] share0_low;
        logic [HALF_W-1:0] share1_low;
    } round_beat_t;

    // one xorshift64 step, shifts 13, 7, 17
    function automatic logic [RNG_W-1:0] xorshift64(input logic [RNG_W-1:0] s);
        logic [RNG_W-1:0] x;
        x = s;
        x = x ^ (x << 13);
        x = x ^ (x >> 7);
        x = x ^ (x << 17);
        return x;
    endfunction

endpackage

### hw/rtl/mp80ks_round.sv
`timescale 1ns / 1ps

module mp80ks_round
    import mp80ks_pkg::*;
(
    input  logic [KEY_W-1:0] key_i,
    input  logic [RND_W-1:0] rnd_i,
    input  logic [RNG_W-1:0] rng_i,
    output round_beat_t      beat_o,
    output logic [KEY_W-1:0] key_next_o,
    output logic [RNG_W-1:0] rng_next_o
);

    logic [RK_W-1:0]  round_key;
    logic [RNG_W-1:0] rng_mid;
    logic [KEY_W-1:0] key_rot;
    logic [RND_W-1:0] cnt;

    // generator steps twice: high half mask first
    assign rng_mid    = xorshift64(rng_i);
    assign rng_next_o = xorshift64(rng_mid);

    assign round_key = key_i[KEY_W-1 -: RK_W];

    always_comb begin
        beat_o.round_index = rnd_i;
        beat_o.share0_high = rng_mid[HALF_W-1:0];
        beat_o.share1_high = rng_mid[HALF_W-1:0] ^ round_key[RK_W-1 -: HALF_W];
        beat_o.share0_low  = rng_next_o[HALF_W-1:0];
        beat_o.share1_low  = rng_next_o[HALF_W-1:0] ^ round_key[HALF_W-1:0];
    end

    // key update for the next round: rotate, s-box on top nibble, counter xor
    assign cnt     = rnd_i + RND_W'(1);
    assign key_rot = {key_i[ROT_R-1:0], key_i[KEY_W-1:ROT_R]};

    always_comb begin
        key_next_o = key_rot;
        key_next_o[KEY_W-1 -: 4] = SBOX[key_rot[KEY_W-1 -: 4]];
        key_next_o[CNT_LSB +: RND_W] = key_rot[CNT_LSB +: RND_W] ^ cnt;
    end

endmodule

### hw/rtl/masked_present80_key_schedule_top.sv
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+-----------------------------------------
// s_       | in  | s_valid / s_ready  | s_key_high[15:0], s_key_low[63:0]
// m_       | out | m_valid / m_ready  | m_round_index, m_share0/1_high/low, m_last_round
// cfg_     | in  | cfg_wr_en          | cfg_wr_data[63:0] (generator seed)
//
// one round key beat per cycle while m_ready is high; a key yields ROUND_KEYS beats,
// all of them made by the single round unit
// a taken key reaches the output through the key buffer, working key reg, then result reg
// a one-entry key buffer takes the next key while the current one is still expanding
// m_ready low on a full output freezes round unit and generator; nothing lost or repeated
// aresetn is synchronous, active low; the generator resets to its default seed
`timescale 1ns / 1ps

module masked_present80_key_schedule_top
    import mp80ks_pkg::*;
#(
    parameter int ROUND_KEYS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_wr_en,
    input  logic [RNG_W-1:0]  cfg_wr_data,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [15:0]       s_key_high,
    input  logic [63:0]       s_key_low,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [RND_W-1:0]  m_round_index,
    output logic [HALF_W-1:0] m_share0_high,
    output logic [HALF_W-1:0] m_share1_high,
    output logic [HALF_W-1:0] m_share0_low,
    output logic [HALF_W-1:0] m_share1_low,
    output logic              m_last_round
);

    localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUND_KEYS - 1);

    // key buffer (skid between input channel and the round unit)
    logic              pend_valid_reg, pend_valid_next;
    logic [KEY_W-1:0]  pend_key_reg;

    // working state of the expansion
    logic              busy_reg, busy_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [RNG_W-1:0]  rng_reg, rng_next;

    // result register
    logic              m_valid_reg, m_valid_next;
    round_beat_t       beat_reg;
    logic              last_reg;

    // round unit outputs
    round_beat_t       beat_w;
    logic [KEY_W-1:0]  key_upd_w;
    logic [RNG_W-1:0]  rng_upd_w;

    logic              s_take;
    logic              out_free;
    logic              fire;
    logic              is_last;
    logic              load;

    mp80ks_round u_round (
        .key_i      (key_reg),
        .rnd_i      (rnd_reg),
        .rng_i      (rng_reg),
        .beat_o     (beat_w),
        .key_next_o (key_upd_w),
        .rng_next_o (rng_upd_w)
    );

    assign s_ready  = !pend_valid_reg;
    assign s_take   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign fire     = busy_reg && out_free;        // one round key beat leaves the unit
    assign is_last  = (rnd_reg == LAST_RND);
    // start the next key right behind the last round of the current one
    assign load     = pend_valid_reg && (!busy_reg || (fire && is_last));

    always_comb begin
        pend_valid_next = (pend_valid_reg && !load) || s_take;

        busy_next = busy_reg;
        rnd_next  = rnd_reg;
        key_next  = key_reg;
        if (load) begin
            busy_next = 1'b1;
            rnd_next  = '0;
            key_next  = pend_key_reg;
        end else if (fire) begin
            busy_next = !is_last;
            rnd_next  = is_last ? '0 : rnd_reg + RND_W'(1);
            key_next  = key_upd_w;
        end

        // seed writes are to come only while idle; the block itself does not enforce this
        if (cfg_wr_en) begin
            rng_next = cfg_wr_data;
        end else if (fire) begin
            rng_next = rng_upd_w;
        end else begin
            rng_next = rng_reg;
        end

        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            busy_reg       <= 1'b0;
            rnd_reg        <= '0;
            rng_reg        <= RNG_SEED_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            busy_reg       <= busy_next;
            rnd_reg        <= rnd_next;
            rng_reg        <= rng_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        if (s_take) begin
            pend_key_reg <= {s_key_high, s_key_low};
        end
        if (fire) begin
            beat_reg <= beat_w;
            last_reg <= is_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_round_index = beat_reg.round_index;
    assign m_share0_high = beat_reg.share0_high;
    assign m_share1_high = beat_reg.share1_high;
    assign m_share0_low  = beat_reg.share0_low;
    assign m_share1_low  = beat_reg.share1_low;
    assign m_last_round  = last_reg;

    // a beat produced by the round unit is presented next cycle
    a_fire_to_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid)
        else $error("round beat produced but output not valid");

    // the last-round flag only ever marks the final round index
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_round) |-> (m_round_index == LAST_RND))
        else $error("last_round on a non-final round index");

    // an idle round unit sits at round zero
    a_idle_rnd: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (rnd_reg == '0))
        else $error("round counter nonzero while idle");

    // a buffered key starts at once when the unit is idle
    a_pend_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && !busy_reg) |=> (busy_reg && rnd_reg == '0))
        else $error("buffered key not started");

    // a stalled output freezes the generator
    a_rng_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && !cfg_wr_en) |=> $stable(rng_reg))
        else $error("generator advanced during output stall");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

// checks masked_present80_key_schedule_top against an in-bench expansion of
// the key schedule and the xorshift64 mask generator

module tb;
    import mp80ks_pkg::*;

    // one round key per master key round, expected and observed
    localparam int NUM_ROUNDS     = 32;
    localparam int DIRECTED_ROWS  = 12;
    localparam int KEYS_PER_CHUNK = 30;
    localparam int LONG_HOLD      = 300;  // receiver hold-off, long enough to back up the input
    localparam int DRAIN_TAIL     = 8;    // settle time after the last expected beat
    localparam int WATCHDOG_LIMIT = 2000; // cycles with no beat on either channel

    typedef struct packed {
        logic [RND_W-1:0]  round_index;
        logic [HALF_W-1:0] share0_high;
        logic [HALF_W-1:0] share1_high;
        logic [HALF_W-1:0] share0_low;
        logic [HALF_W-1:0] share1_low;
        logic              last_round;
    } round_key_beat_t;

    // one row of the directed part; typed_rk0 marks rows under a zero seed,
    // where round 0 reads straight off the master key
    typedef struct packed {
        logic        seed_wr;
        logic [63:0] seed;
        logic [15:0] key_high;
        logic [63:0] key_low;
        logic        typed_rk0;
        logic [31:0] rk0_high;
        logic [31:0] rk0_low;
    } directed_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [RNG_W-1:0]  cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [15:0]       s_key_high = '0;
    logic [63:0]       s_key_low = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [RND_W-1:0]  m_round_index;
    logic [HALF_W-1:0] m_share0_high;
    logic [HALF_W-1:0] m_share1_high;
    logic [HALF_W-1:0] m_share0_low;
    logic [HALF_W-1:0] m_share1_low;
    logic              m_last_round;

    // predictor state: the generator as the block should hold it
    logic [RNG_W-1:0]  mask_gen_state = RNG_SEED_RESET;
    round_key_beat_t   pending_round_keys [$];

    int mismatches      = 0;
    int keys_sent       = 0;
    int round_keys_seen = 0;
    int seeds_loaded    = 0;
    int idle_cycles     = 0;

    // idle mix, in percent of cycles
    int valid_idle_pct = 11;
    int ready_idle_pct = 45;

    // long hold-off requests, served by the receiver process
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    masked_present80_key_schedule_top #(
        .ROUND_KEYS    (NUM_ROUNDS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_key_high    (s_key_high),
        .s_key_low     (s_key_low),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_round_index (m_round_index),
        .m_share0_high (m_share0_high),
        .m_share1_high (m_share1_high),
        .m_share0_low  (m_share0_low),
        .m_share1_low  (m_share1_low),
        .m_last_round  (m_last_round)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // 4-bit s-box of the cipher
    function automatic logic [3:0] sub_nibble(input logic [3:0] n);
        case (n)
            4'h0: return 4'hC;
            4'h1: return 4'h5;
            4'h2: return 4'h6;
            4'h3: return 4'hB;
            4'h4: return 4'h9;
            4'h5: return 4'h0;
            4'h6: return 4'hA;
            4'h7: return 4'hD;
            4'h8: return 4'h3;
            4'h9: return 4'hE;
            4'hA: return 4'hF;
            4'hB: return 4'h8;
            4'hC: return 4'h4;
            4'hD: return 4'h7;
            4'hE: return 4'h1;
            default: return 4'h2;
        endcase
    endfunction

    // xorshift64 with shifts 13, 7, 17
    function automatic logic [63:0] advance_mask_gen(input logic [63:0] s);
        logic [63:0] x;
        x = s;
        x = x ^ (x << 13);
        x = x ^ (x >> 7);
        x = x ^ (x << 17);
        return x;
    endfunction

    // expand one master key into its round key beats, drawing two masks per round
    function automatic void expand_master_key(input logic [15:0] kh, input logic [63:0] kl,
                                              input logic typed, input logic [31:0] t_high,
                                              input logic [31:0] t_low);
        logic [79:0]     kreg;
        logic [63:0]     rk;
        logic [31:0]     mask_high;
        logic [31:0]     mask_low;
        round_key_beat_t beat;
        kreg = {kh, kl};
        for (int r = 0; r < NUM_ROUNDS; r++) begin
            rk = kreg[79:16];
            mask_gen_state = advance_mask_gen(mask_gen_state);
            mask_high = mask_gen_state[31:0];
            mask_gen_state = advance_mask_gen(mask_gen_state);
            mask_low = mask_gen_state[31:0];
            beat.round_index = 5'(r);
            beat.share0_high = mask_high;
            beat.share1_high = mask_high ^ rk[63:32];
            beat.share0_low  = mask_low;
            beat.share1_low  = mask_low ^ rk[31:0];
            beat.last_round  = (r == NUM_ROUNDS - 1);
            // zero seed: no mask, round 0 is the top of the master key
            if (typed && r == 0) begin
                beat.share0_high = '0;
                beat.share1_high = t_high;
                beat.share0_low  = '0;
                beat.share1_low  = t_low;
            end
            pending_round_keys.push_back(beat);
            // rotate left 61, s-box on the top nibble, round counter into bits 19..15
            kreg = {kreg[18:0], kreg[79:19]};
            kreg[79:76] = sub_nibble(kreg[79:76]);
            kreg[19:15] = kreg[19:15] ^ 5'(r + 1);
        end
    endfunction

    // directed stimulus: extremes, walking bits, zero seed and seed extremes
    function automatic directed_row_t directed_row(input int i);
        case (i)
            // default seed after reset
            0:  return '{1'b0, 64'h0, 16'h0000, 64'h0000_0000_0000_0000, 1'b0, 32'h0, 32'h0};
            1:  return '{1'b0, 64'h0, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0, 32'h0};
            // zero seed, round 0 shares are zero and the plain round key
            2:  return '{1'b1, 64'h0, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                         1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
            3:  return '{1'b0, 64'h0, 16'h1234, 64'h5678_9ABC_DEF0_1234,
                         1'b1, 32'h1234_5678, 32'h9ABC_DEF0};
            4:  return '{1'b0, 64'h0, 16'h0000, 64'h0000_0000_0000_0000,
                         1'b1, 32'h0000_0000, 32'h0000_0000};
            // smallest and largest seeds
            5:  return '{1'b1, 64'h1, 16'hAAAA, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 32'h0, 32'h0};
            6:  return '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 16'h5555, 64'h5555_5555_5555_5555,
                         1'b0, 32'h0, 32'h0};
            7:  return '{1'b1, 64'h0123_4567_89AB_CDEF, 16'h8000, 64'h0000_0000_0000_0001,
                         1'b0, 32'h0, 32'h0};
            8:  return '{1'b0, 64'h0, 16'h0001, 64'h8000_0000_0000_0000, 1'b0, 32'h0, 32'h0};
            9:  return '{1'b0, 64'h0, 16'h0F0F, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0, 32'h0, 32'h0};
            10: return '{1'b1, 64'h0, 16'h8000, 64'h0000_0000_0000_0001,
                         1'b1, 32'h8000_0000, 32'h0000_0000};
            default: return '{1'b1, 64'h1, 16'hC3A5, 64'h0123_4567_89AB_CDEF,
                              1'b0, 32'h0, 32'h0};
        endcase
    endfunction

    // offer one master key and hold it until taken; predict on acceptance
    task automatic send_key(input logic [15:0] kh, input logic [63:0] kl, input logic typed,
                            input logic [31:0] t_high, input logic [31:0] t_low);
        while ($urandom_range(99) < valid_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_key_high <= kh;
        s_key_low  <= kl;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        expand_master_key(kh, kl, typed, t_high, t_low);
        keys_sent++;
    endtask

    // stop offering and wait for every expected beat, then let the block settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_round_keys.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    // seed write, only issued with the block idle
    task automatic load_seed(input logic [63:0] seed);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= seed;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mask_gen_state = seed;
        seeds_loaded++;
    endtask

    // mostly random key fields with some all-zero and all-one values mixed in
    function automatic logic [63:0] pick_key_bits();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // receiver: random ready, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= ready_idle_pct);
        end
    end

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    // result monitor and watchdog
    always @(posedge aclk) begin
        round_key_beat_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d round keys outstanding",
                         $time, idle_cycles, pending_round_keys.size());
                $display("tb failed");
                $finish;
            end
            if (m_valid && m_ready) begin
                round_keys_seen++;
                if (pending_round_keys.size() == 0) begin
                    $display("%0t: unexpected round key beat, expected none, actual round %0d",
                             $time, m_round_index);
                    mismatches++;
                end else begin
                    want = pending_round_keys.pop_front();
                    check_field("round_index", 32'(want.round_index), 32'(m_round_index));
                    check_field("share0_high", want.share0_high, m_share0_high);
                    check_field("share1_high", want.share1_high, m_share1_high);
                    check_field("share0_low", want.share0_low, m_share0_low);
                    check_field("share1_low", want.share1_low, m_share1_low);
                    check_field("last_round", 32'(want.last_round), 32'(m_last_round));
                end
            end
        end
    end

    // stimulus
    initial begin
        directed_row_t row;
        logic [63:0]   seed;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table, with the first idle mix
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = directed_row(i);
            if (row.seed_wr) begin
                wait_drained();
                load_seed(row.seed);
            end
            send_key(row.key_high, row.key_low, row.typed_rk0, row.rk0_high, row.rk0_low);
        end

        // random keys: three idle mixes, a fresh seed per chunk
        for (int mix = 0; mix < 3; mix++) begin
            case (mix)
                0: begin
                    valid_idle_pct = 11;
                    ready_idle_pct = 45;
                end
                1: begin
                    valid_idle_pct = 45;
                    ready_idle_pct = 11;
                end
                default: begin
                    valid_idle_pct = 0;
                    ready_idle_pct = 0;
                end
            endcase
            for (int chunk = 0; chunk < 3; chunk++) begin
                // sender pause until the block has delivered everything
                wait_drained();
                seed = {$urandom, $urandom};
                if (seed == '0) seed = 64'h1;
                load_seed(seed);
                // first chunk of mixes 0 and 2: receiver holds off while keys keep coming, backing up the input
                if (chunk == 0 && mix != 1) hold_requests++;
                for (int k = 0; k < KEYS_PER_CHUNK; k++) begin
                    send_key(16'(pick_key_bits()), pick_key_bits(), 1'b0, '0, '0);
                end
            end
        end

        wait_drained();
        $display("covered %0d master keys, %0d round key beats checked, %0d seed loads",
                 keys_sent, round_keys_seen, seeds_loaded);
        $display("idle mixes 11/45, 45/11 and none, %0d long receiver hold-offs, %0d mismatches",
                 hold_requests, mismatches);
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/mp80ks_pkg.sv
hw/rtl/mp80ks_round.sv
hw/rtl/masked_present80_key_schedule_top.sv
tb/sv/tb.sv
